@@ sv/jpdz_pkg.sv @@
// ----------------------------------------------------------------------------
// jpdz_pkg: shared types and constants for the joystick polar dead zone block
// Holds field widths, register codes, controller states, the command and
// status bundles between controller and datapath, and the arctangent table.
// ----------------------------------------------------------------------------
package jpdz_pkg;

    // field widths
    localparam int RAW_W   = 8;
    localparam int SIZE_W  = 15;
    localparam int ANGLE_W = 17;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE_HALF = 1'b1;

    // direction modes
    localparam logic [1:0] MODE_SNAP8 = 2'd0;
    localparam logic [1:0] MODE_SNAP4 = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;

    // register reset values
    localparam logic [1:0]                MODE_RESET       = MODE_SNAP8;
    localparam logic [RAW_W-1:0]          DZ_HALF_RESET    = 8'd60;
    localparam logic signed [ANGLE_W-1:0] LAST_ANGLE_RESET = 17'sd16384;

    // cordic vector and angle accumulator widths
    localparam int CW = 28;
    localparam int ZW = 18;

    // square root: 48-bit radicand, one result bit per step
    localparam int SQ_W       = 48;
    localparam int SQRT_STEPS = 24;
    localparam int CNT_W      = 5;
    localparam logic [13:0] SQRT_SCALE = 14'd10000;

    // ceil(2^32 / 255), exact for roots below 2^24
    localparam logic [24:0] RECIP_255 = 25'd16843010;
    localparam logic [16:0] SIZE_MAX  = 17'd25600;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SCALE,
        ST_ITER,
        ST_DIV,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic load;
        logic square;
        logic scale;
        logic iter;
        logic div;
        logic write;
    } t_dp_cmd;

    typedef struct packed {
        logic dead;
        logic iter_last;
        logic out_free;
    } t_dp_sts;

    // atan(2^-i) in binary angle units, 32768 is pi
    function automatic logic [13:0] atan_unit(input logic [CNT_W-1:0] idx);
        logic [13:0] v;
        case (idx)
            5'd0:    v = 14'd8192;
            5'd1:    v = 14'd4836;
            5'd2:    v = 14'd2555;
            5'd3:    v = 14'd1297;
            5'd4:    v = 14'd651;
            5'd5:    v = 14'd326;
            5'd6:    v = 14'd163;
            5'd7:    v = 14'd81;
            5'd8:    v = 14'd41;
            5'd9:    v = 14'd20;
            5'd10:   v = 14'd10;
            5'd11:   v = 14'd5;
            5'd12:   v = 14'd3;
            5'd13:   v = 14'd1;
            5'd14:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/jpdz_in_if.sv @@
// ----------------------------------------------------------------------------
// jpdz_in_if: input channel carrying one pair of raw axis readings
// Valid/ready handshake, a beat moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface jpdz_in_if import jpdz_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] horiz_raw;
    logic [RAW_W-1:0] vert_raw;

    modport source (output valid, output horiz_raw, output vert_raw, input ready);
    modport sink   (input valid, input horiz_raw, input vert_raw, output ready);
endinterface

@@ sv/jpdz_out_if.sv @@
// ----------------------------------------------------------------------------
// jpdz_out_if: output channel carrying magnitude, direction and dead zone flag
// Valid/ready handshake, a beat moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface jpdz_out_if import jpdz_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [SIZE_W-1:0]         size_percent;
    logic signed [ANGLE_W-1:0] angle;
    logic                      in_dead_zone;

    modport source (output valid, output size_percent, output angle,
                    output in_dead_zone, input ready);
    modport sink   (input valid, input size_percent, input angle,
                    input in_dead_zone, output ready);
endinterface

@@ sv/jpdz_ctrl.sv @@
// ----------------------------------------------------------------------------
// jpdz_ctrl: sequencer for the joystick polar dead zone block
// Steps one beat through load, squaring, scaling, the shared iteration
// phase, division and write-back, which waits for a free output register.
// ----------------------------------------------------------------------------
module jpdz_ctrl import jpdz_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SQUARE;
            end
            ST_SQUARE: begin
                n_state = i_sts.dead ? ST_WRITE : ST_SCALE;
            end
            ST_SCALE: begin
                n_state = ST_ITER;
            end
            ST_ITER: begin
                if (i_sts.iter_last) n_state = ST_DIV;
            end
            ST_DIV: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SQUARE: begin
                o_cmd.square = 1'b1;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
            end
            ST_ITER: begin
                o_cmd.iter = 1'b1;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
            end
            ST_WRITE: begin
                o_cmd.write = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // never two datapath operations in one cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.square, o_cmd.scale, o_cmd.iter,
                  o_cmd.div, o_cmd.write}))
        else $error("more than one datapath command at once");

    // an accepted beat always moves on to squaring
    a_load_to_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == ST_SQUARE)
        else $error("load not followed by squaring");

endmodule

@@ sv/jpdz_dp.sv @@
// ----------------------------------------------------------------------------
// jpdz_dp: datapath of the joystick polar dead zone block
// Centres the axes, tests the dead zone, runs a bit-per-cycle square root
// and an iterative cordic side by side, scales and snaps, and holds the
// configuration, the last angle and the output register.
// ----------------------------------------------------------------------------
module jpdz_dp import jpdz_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_sts                   o_sts,
    input  logic [RAW_W-1:0]          i_horiz_raw,
    input  logic [RAW_W-1:0]          i_vert_raw,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [SIZE_W-1:0]         o_size_percent,
    output logic signed [ANGLE_W-1:0] o_angle,
    output logic                      o_in_dead_zone
);

    // configuration and state
    logic [1:0]                r_mode;
    logic [RAW_W-1:0]          r_dz_half;
    logic signed [ANGLE_W-1:0] r_last_angle;

    // working registers
    logic signed [9:0]         r_cx;
    logic signed [9:0]         r_cy;
    logic                      r_dead;
    logic [15:0]               r_sq_x;
    logic [15:0]               r_sq_y;
    logic [SQ_W-1:0]           r_rem;
    logic [SQ_W-1:0]           r_root;
    logic [SQ_W-1:0]           r_bit;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [CW-1:0]      r_x;
    logic signed [CW-1:0]      r_y;
    logic signed [ZW-1:0]      r_z;
    logic [16:0]               r_quot;
    logic signed [ANGLE_W-1:0] r_angle_new;

    // output register
    logic                      r_out_valid;
    logic [SIZE_W-1:0]         r_out_size;
    logic signed [ANGLE_W-1:0] r_out_angle;
    logic                      r_out_dead;

    // centring in doubled units and dead zone test
    logic signed [9:0] w_cx;
    logic signed [9:0] w_cy;
    logic [9:0]        w_ax;
    logic [9:0]        w_ay;
    logic              w_dead;

    assign w_cx   = $signed({1'b0, i_horiz_raw, 1'b0}) - 10'sd255;
    assign w_cy   = $signed({1'b0, i_vert_raw, 1'b0}) - 10'sd255;
    assign w_ax   = w_cx[9] ? 10'(-w_cx) : 10'(w_cx);
    assign w_ay   = w_cy[9] ? 10'(-w_cy) : 10'(w_cy);
    assign w_dead = (w_ax < {2'b00, r_dz_half}) && (w_ay < {2'b00, r_dz_half});

    // squares and cordic pre-rotation into the right half plane
    logic signed [19:0] w_sqx;
    logic signed [19:0] w_sqy;
    logic signed [9:0]  w_ncx;
    logic signed [9:0]  w_ncy;
    logic signed [9:0]  w_x0;
    logic signed [9:0]  w_y0;
    logic signed [ZW-1:0] w_z0;

    assign w_sqx = r_cx * r_cx;
    assign w_sqy = r_cy * r_cy;
    assign w_ncx = -r_cx;
    assign w_ncy = -r_cy;

    always_comb begin
        if (r_cx[9] && !r_cy[9]) begin
            w_x0 = r_cy;
            w_y0 = w_ncx;
            w_z0 = 18'sd16384;
        end else if (r_cx[9]) begin
            w_x0 = w_ncy;
            w_y0 = r_cx;
            w_z0 = -18'sd16384;
        end else begin
            w_x0 = r_cx;
            w_y0 = r_cy;
            w_z0 = '0;
        end
    end

    // radicand: (x^2 + y^2) * 10000 * 65536
    logic [16:0] w_sum;
    logic [30:0] w_scaled;

    assign w_sum    = {1'b0, r_sq_x} + {1'b0, r_sq_y};
    assign w_scaled = 31'(w_sum) * 31'(SQRT_SCALE);

    // one square root step
    logic [SQ_W-1:0] w_trial;
    assign w_trial = r_root + r_bit;

    // one cordic vectoring step
    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;
    logic signed [ZW-1:0] w_atan;
    logic                 w_cordic_en;

    assign w_dx        = r_y >>> r_cnt;
    assign w_dy        = r_x >>> r_cnt;
    assign w_atan      = $signed({{(ZW-14){1'b0}}, atan_unit(r_cnt)});
    assign w_cordic_en = int'(r_cnt) < CORDIC_STEPS;

    // divide the root by 255 through the reciprocal
    logic [48:0] w_prod;
    assign w_prod = 49'(r_root[23:0]) * 49'(RECIP_255);

    // clamp and snap the angle
    logic signed [ZW-1:0] w_zc;
    logic signed [ZW-1:0] w_t8;
    logic signed [ZW-1:0] w_t4;
    logic signed [ZW-1:0] w_snap;

    always_comb begin
        if (r_z > 18'sd32768) begin
            w_zc = 18'sd32768;
        end else if (r_z < -18'sd32768) begin
            w_zc = -18'sd32768;
        end else begin
            w_zc = r_z;
        end
        w_t8 = w_zc + 18'sd4095;
        w_t4 = w_zc + 18'sd8191;
        case (r_mode)
            MODE_SNAP8: w_snap = {w_t8[ZW-1:13], 13'b0};
            MODE_SNAP4: w_snap = {w_t4[ZW-1:14], 14'b0};
            default:    w_snap = w_zc;
        endcase
    end

    // saturated magnitude
    logic [SIZE_W-1:0] w_size;
    assign w_size = (r_quot > SIZE_MAX) ? SIZE_MAX[SIZE_W-1:0] : r_quot[SIZE_W-1:0];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_RESET;
            r_dz_half <= DZ_HALF_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIRECTION_MODE: r_mode    <= i_cfg_data[1:0];
                CFG_DEAD_ZONE_HALF: r_dz_half <= i_cfg_data;
                default:            r_mode    <= r_mode;
            endcase
        end
    end

    // working datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx   <= w_cx;
            r_cy   <= w_cy;
            r_dead <= w_dead;
        end
        if (i_cmd.square) begin
            r_sq_x <= w_sqx[15:0];
            r_sq_y <= w_sqy[15:0];
            r_x    <= {{2{w_x0[9]}}, w_x0, 16'b0};
            r_y    <= {{2{w_y0[9]}}, w_y0, 16'b0};
            r_z    <= w_z0;
        end
        if (i_cmd.scale) begin
            r_rem  <= {1'b0, w_scaled, 16'b0};
            r_root <= '0;
            r_bit  <= SQ_W'(1) << (SQ_W - 2);
            r_cnt  <= '0;
        end
        if (i_cmd.iter) begin
            if (r_rem >= w_trial) begin
                r_rem  <= r_rem - w_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt + 1'b1;
            if (w_cordic_en) begin
                if (!r_y[CW-1]) begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_atan;
                end else begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_atan;
                end
            end
        end
        if (i_cmd.div) begin
            r_quot      <= w_prod[48:32];
            r_angle_new <= w_snap[ANGLE_W-1:0];
        end
    end

    // last angle and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_angle <= LAST_ANGLE_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.write && !r_dead) begin
                r_last_angle <= r_angle_new;
            end
            if (i_cmd.write) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_out_size  <= r_dead ? '0 : w_size;
            r_out_angle <= r_dead ? r_last_angle : r_angle_new;
            r_out_dead  <= r_dead;
        end
    end

    // status back to the controller
    assign o_sts.dead      = r_dead;
    assign o_sts.iter_last = (r_cnt == CNT_W'(SQRT_STEPS - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_size_percent = r_out_size;
    assign o_angle        = r_out_angle;
    assign o_in_dead_zone = r_out_dead;

    // a result is only written into a free output register
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |-> o_sts.out_free)
        else $error("output register overwritten");

    // magnitude never exceeds full scale
    a_size_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_size <= SIZE_MAX[SIZE_W-1:0])
        else $error("magnitude above full scale");

    // dead zone results carry zero magnitude and the held angle
    a_dead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.write && r_dead) |=> (r_out_size == '0 && r_out_angle == r_last_angle))
        else $error("dead zone result not zero or angle not held");

endmodule

@@ sv/joystick_polar_dead_zone.sv @@
// ----------------------------------------------------------------------------
// joystick_polar_dead_zone: joystick axes to magnitude and direction
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one beat of raw horizontal and vertical readings; o_out
//   returns one beat per input with size_percent (percent times 256,
//   saturated at 25600), angle (32768 is pi) and in_dead_zone.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   the block is idle: index 0 direction_mode, index 1 dead_zone_half.
// Sequencing:
//   one beat is in flight at a time. Outside the dead zone a beat passes
//   from acceptance to o_out.valid through load, squaring, scaling,
//   24 square root iterations (with the CORDIC_STEPS cordic steps run in
//   the same cycles), division and write-back. The 24-step square root,
//   not the cordic, sets the length of the iteration phase. A dead zone
//   beat goes from squaring straight to write-back. i_in.ready returns
//   in the cycle after the result is written.
// Reset (synchronous, active low) clears the sequencer and output valid,
//   sets direction_mode 0, dead_zone_half 60 and the held angle to 90 deg.
// When the receiver stalls, the finished result waits in the output
//   register; the next beat is still accepted and worked on, and holds
//   only at write-back until the output register frees.
// ----------------------------------------------------------------------------
module joystick_polar_dead_zone import jpdz_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    jpdz_in_if.sink               i_in,
    jpdz_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer
    jpdz_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // datapath
    jpdz_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_horiz_raw    (i_in.horiz_raw),
        .i_vert_raw     (i_in.vert_raw),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_size_percent (o_out.size_percent),
        .o_angle        (o_out.angle),
        .o_in_dead_zone (o_out.in_dead_zone)
    );

endmodule
